[src/smkv_pkg.sv]
// ---------------------------------------------------------------------------
// smkv_pkg: shared definitions for the sparse key/value table
// Table size, command and status codes, and the control bundle that the
// sequencer sends to the table storage.
// ---------------------------------------------------------------------------
package smkv_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_CLEAR  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef struct packed {
      logic [IDX_W-1:0]  addr_rd_idx;
      logic [IDX_W-1:0]  val_rd_idx;
      logic [IDX_W-1:0]  wr_idx;
      logic              wr_addr_en;
      logic              wr_val_en;
      logic [KEY_W-1:0]  wr_address;
      logic [DATA_W-1:0] wr_value;
      logic              set_valid;
      logic              clr_valid;
      logic              clr_all;
   } store_ctrl_type;

endpackage

[src/sparse_memory_key_value_table.sv]
// ---------------------------------------------------------------------------
// sparse_memory_key_value_table: bounded associative address/value table
// Write, delete, read and clear commands over a table of address/value
// pairs, searched one entry per cycle by a single key comparator.
//
//   Channel  Direction  Handshake           Payload
//   req_     in         req_valid/ready     command, address, write_data
//   rsp_     out        rsp_valid/ready     status, read_data
//
// A write, delete or read scans the table one entry per cycle through the
// address memory and a single 32-bit comparator; a match ends the scan.
// After the scan, the apply state (then a read wait on a read hit) prepares
// the result; a clear skips the scan. A new request is accepted only when idle.
// Reset empties the table at once; no clearing pass is needed.
// A stalled result holds in the output register; the sequencer waits for it.
// ---------------------------------------------------------------------------
module sparse_memory_key_value_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_command,
   input  logic [31:0]         req_address,
   input  logic signed [31:0]  req_write_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_read_data
);
   import smkv_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_READ_WAIT,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   command_type        cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [DATA_W-1:0]  data_ff, data_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               issue_done_ff, issue_done_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   status_type         status_ff, status_in;
   logic [DATA_W-1:0]  rdata_ff, rdata_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   store_ctrl_type     ctrl;
   logic [ENTRIES-1:0] valid;
   logic [KEY_W-1:0]   rd_address;
   logic [DATA_W-1:0]  rd_value;
   logic               hit_now;
   logic               free_now;
   logic               last_cmp;
   logic               out_free;

   smkv_store u_store (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .valid      (valid),
      .rd_address (rd_address),
      .rd_value   (rd_value)
   );

   // The compare stage works on the registered address memory read, in the cycle after the read.
   assign hit_now  = cmp_vld_ff && valid[cmp_idx_ff] && (rd_address == key_ff);
   assign free_now = cmp_vld_ff && !valid[cmp_idx_ff] && !free_found_ff;
   assign last_cmp = cmp_vld_ff && (cmp_idx_ff == LAST_IDX);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      data_in       = data_ff;
      scan_idx_in   = scan_idx_ff;
      issue_done_in = issue_done_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_vld_in    = 1'b0;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      status_in     = status_ff;
      rdata_in      = rdata_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;

      ctrl             = '0;
      ctrl.addr_rd_idx = scan_idx_ff;
      ctrl.val_rd_idx  = hit_idx_ff;
      ctrl.wr_address  = key_ff;
      ctrl.wr_value    = data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = command_type'(req_command);
               key_in        = req_address;
               data_in       = req_write_data;
               scan_idx_in   = '0;
               issue_done_in = 1'b0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               state_in      = (command_type'(req_command) == CMD_CLEAR) ? S_APPLY : S_SCAN;
            end
         end
         S_SCAN: begin
            cmp_vld_in = !issue_done_ff;
            cmp_idx_in = scan_idx_ff;
            if (scan_idx_ff == LAST_IDX) begin
               issue_done_in = 1'b1;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (free_now) begin
               free_found_in = 1'b1;
               free_idx_in   = cmp_idx_ff;
            end
            if (hit_now) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
            end
            if (hit_now || last_cmp) begin
               cmp_vld_in = 1'b0;
               state_in   = S_APPLY;
            end
         end
         S_APPLY: begin
            status_in = ST_DONE;
            rdata_in  = '0;
            state_in  = S_DONE;
            case (cmd_ff)
               CMD_WRITE: begin
                  if (hit_ff) begin
                     ctrl.wr_idx    = hit_idx_ff;
                     ctrl.wr_val_en = 1'b1;
                  end else if (free_found_ff) begin
                     ctrl.wr_idx     = free_idx_ff;
                     ctrl.wr_val_en  = 1'b1;
                     ctrl.wr_addr_en = 1'b1;
                     ctrl.set_valid  = 1'b1;
                  end else begin
                     status_in = ST_FULL;
                  end
               end
               CMD_DELETE: begin
                  if (hit_ff) begin
                     ctrl.wr_idx    = hit_idx_ff;
                     ctrl.clr_valid = 1'b1;
                  end else begin
                     status_in = ST_ABSENT;
                  end
               end
               CMD_READ: begin
                  // The value memory is read at the hit entry this cycle.
                  if (hit_ff) begin
                     state_in = S_READ_WAIT;
                  end else begin
                     status_in = ST_ABSENT;
                  end
               end
               default: begin
                  ctrl.clr_all = 1'b1;
               end
            endcase
         end
         S_READ_WAIT: begin
            rdata_in = rd_value;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = rdata_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         cmp_vld_ff    <= cmp_vld_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      data_ff       <= data_in;
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      status_ff     <= status_in;
      rdata_ff      <= rdata_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

[src/smkv_store.sv]
// ---------------------------------------------------------------------------
// smkv_store: table storage
// Valid flags in flip-flops, and address and value memories with one write
// port and one registered read port each.
// ---------------------------------------------------------------------------
module smkv_store (
   input  logic                                 clock,
   input  logic                                 reset,
   input  smkv_pkg::store_ctrl_type             ctrl,
   output logic [smkv_pkg::ENTRIES-1:0]         valid,
   output logic [smkv_pkg::KEY_W-1:0]           rd_address,
   output logic [smkv_pkg::DATA_W-1:0]          rd_value
);
   import smkv_pkg::*;

   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [KEY_W-1:0]   addr_mem_ff [ENTRIES];
   logic [DATA_W-1:0]  val_mem_ff  [ENTRIES];
   logic [KEY_W-1:0]   rd_address_ff;
   logic [DATA_W-1:0]  rd_value_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clr_all) begin
         valid_in = '0;
      end else if (ctrl.set_valid) begin
         valid_in[ctrl.wr_idx] = 1'b1;
      end else if (ctrl.clr_valid) begin
         valid_in[ctrl.wr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_addr_en) begin
         addr_mem_ff[ctrl.wr_idx] <= ctrl.wr_address;
      end
      rd_address_ff <= addr_mem_ff[ctrl.addr_rd_idx];
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_val_en) begin
         val_mem_ff[ctrl.wr_idx] <= ctrl.wr_value;
      end
      rd_value_ff <= val_mem_ff[ctrl.val_rd_idx];
   end

   assign valid      = valid_ff;
   assign rd_address = rd_address_ff;
   assign rd_value   = rd_value_ff;

endmodule
